>>> rtl/erv_pkg.sv
package erv_pkg;

  localparam int CordicStepsDefault = 24;
  localparam int AngleW = 16;
  localparam int CoefW = 32;
  localparam int VecW = 32;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_Z = 2'd2;

  localparam logic signed [CoefW-1:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [CoefW-1:0] NEG_ONE_Q30 = -32'sd1073741824;
  localparam logic signed [CoefW-1:0] CORDIC_X0 = 32'sd652032874;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  typedef struct packed {
    logic op;
    logic signed [VecW-1:0] in_x;
    logic signed [VecW-1:0] in_y;
    logic signed [VecW-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [VecW-1:0] out_x;
    logic signed [VecW-1:0] out_y;
    logic signed [VecW-1:0] out_z;
  } out_item_t;

  typedef logic signed [CoefW-1:0] coef_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'sh03243F6A8;
      5'd1: atan_q30 = 34'sh01DAC6705;
      5'd2: atan_q30 = 34'sh00FADBAFC;
      5'd3: atan_q30 = 34'sh007F56EA6;
      5'd4: atan_q30 = 34'sh003FEAB76;
      5'd5: atan_q30 = 34'sh001FFD55B;
      5'd6: atan_q30 = 34'sh000FFFAAA;
      5'd7: atan_q30 = 34'sh0007FFF55;
      5'd8: atan_q30 = 34'sh0003FFFEA;
      5'd9: atan_q30 = 34'sh0001FFFFD;
      5'd10: atan_q30 = 34'sh0000FFFFF;
      5'd11: atan_q30 = 34'sh00007FFFF;
      5'd12: atan_q30 = 34'sh00003FFFF;
      5'd13: atan_q30 = 34'sh00001FFFF;
      5'd14: atan_q30 = 34'sh00000FFFF;
      5'd15: atan_q30 = 34'sh000007FFF;
      5'd16: atan_q30 = 34'sh000003FFF;
      5'd17: atan_q30 = 34'sh000001FFF;
      5'd18: atan_q30 = 34'sh000000FFF;
      5'd19: atan_q30 = 34'sh0000007FF;
      5'd20: atan_q30 = 34'sh0000003FF;
      5'd21: atan_q30 = 34'sh0000001FF;
      5'd22: atan_q30 = 34'sh0000000FF;
      5'd23: atan_q30 = 34'sh00000007F;
      5'd24: atan_q30 = 34'sh00000003F;
      5'd25: atan_q30 = 34'sh00000001F;
      5'd26: atan_q30 = 34'sh00000000F;
      5'd27: atan_q30 = 34'sh000000008;
      5'd28: atan_q30 = 34'sh000000004;
      5'd29: atan_q30 = 34'sh000000002;
      5'd30: atan_q30 = 34'sh000000001;
      default: atan_q30 = 34'sh000000000;
    endcase
  endfunction

  // Q1.30 product rounded half up; the result fits 33 bits for clamped inputs.
  function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    mulq = p[63:30];
  endfunction

  function automatic coef_t clamp_q30(input logic signed [33:0] v);
    if (v > 34'sd1073741824) clamp_q30 = ONE_Q30;
    else if (v < -34'sd1073741824) clamp_q30 = NEG_ONE_Q30;
    else clamp_q30 = v[CoefW-1:0];
  endfunction

endpackage

>>> rtl/erv_matrix_build.sv
// Rebuilds the rotation matrix after an angle write. One shared CORDIC
// iterates over the three angles, then a sequencer forms the nine entries
// with one multiply per cycle.
module erv_matrix_build #(
  parameter int CORDIC_STEPS = erv_pkg::CordicStepsDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [erv_pkg::AngleW-1:0] ang_x,
  input  logic signed [erv_pkg::AngleW-1:0] ang_y,
  input  logic signed [erv_pkg::AngleW-1:0] ang_z,
  output logic busy,
  output logic wr_en,
  output logic [3:0] wr_idx,
  output erv_pkg::coef_t wr_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_RAD = 3'd2;
  localparam logic [2:0] ST_ITER = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;
  localparam logic [2:0] ST_MAT = 3'd5;
  localparam int AngleW_L = erv_pkg::AngleW;
  localparam int LastIt = (CORDIC_STEPS > 32 ? 32 : CORDIC_STEPS) - 1;

  logic [2:0] st_r, st_nxt;
  logic [1:0] ang_sel_r;
  logic [4:0] it_r;
  logic [4:0] mstep_r;
  logic [1:0] quad_r, quad_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic signed [33:0] sc_r [6];
  logic signed [33:0] ad_r, bd_r, t_r;
  logic signed [33:0] prod;
  logic signed [33:0] op_a, op_b;
  logic signed [AngleW_L-1:0] ang_cur;
  logic signed [17:0] ang_mod;
  logic [14:0] ang_red;
  logic [25:0] rad_frac;
  logic [17:0] rad_hi;
  logic [36:0] rad_div;
  logic [31:0] rad_q30;
  logic signed [33:0] s_cl, c_cl;

  always_comb begin
    case (ang_sel_r)
      2'd0: ang_cur = ang_x;
      2'd1: ang_cur = ang_y;
      default: ang_cur = ang_z;
    endcase
  end

  // 16-bit angles stay within +-32768, so two conditional adds and one conditional subtract reduce them.
  always_comb begin
    ang_mod = 18'(ang_cur);
    if (ang_mod < 0) ang_mod = ang_mod + 18'sd23040;
    if (ang_mod < 0) ang_mod = ang_mod + 18'sd23040;
    if (ang_mod >= 18'sd23040) ang_mod = ang_mod - 18'sd23040;
    ang_red = ang_mod[14:0];
  end

  // The quadrant comes from three compares against multiples of 90 degrees.
  always_comb begin
    if (ang_red >= 15'd17280) quad_nxt = 2'd3;
    else if (ang_red >= 15'd11520) quad_nxt = 2'd2;
    else if (ang_red >= 15'd5760) quad_nxt = 2'd1;
    else quad_nxt = 2'd0;
    rem_nxt = 13'(ang_red - 15'(quad_nxt) * 15'd5760);
  end

  // The radian value (r*PI_Q30 + 5760)/11520 splits exactly into r*292817
  // plus (r*7586 + 5760)/11520, since PI_Q30 = 292817*11520 + 7586. The
  // small term is divided by 256 with a shift and by 45 with a reciprocal
  // that is exact over its whole range.
  always_comb begin
    rad_frac = 26'(rem_r) * 26'd7586 + 26'd5760;
    rad_hi = rad_frac[25:8];
    rad_div = 37'(rad_hi) * 37'd372828;
    rad_q30 = 32'(rem_r) * 32'd292817 + 32'(rad_div[36:24]);
  end

  assign s_cl = 34'(erv_pkg::clamp_q30(cy_r));
  assign c_cl = 34'(erv_pkg::clamp_q30(cx_r));

  // sc_r: 0 A, 1 B, 2 C, 3 D, 4 E, 5 F
  always_comb begin
    op_a = '0; op_b = '0;
    case (mstep_r)
      5'd0: begin op_a = sc_r[0]; op_b = sc_r[3]; end
      5'd1: begin op_a = sc_r[1]; op_b = sc_r[3]; end
      5'd2: begin op_a = sc_r[2]; op_b = sc_r[4]; end
      5'd3: begin op_a = sc_r[2]; op_b = sc_r[5]; end
      5'd4: begin op_a = bd_r; op_b = sc_r[4]; end
      5'd5: begin op_a = sc_r[0]; op_b = sc_r[5]; end
      5'd6: begin op_a = bd_r; op_b = sc_r[5]; end
      5'd7: begin op_a = sc_r[0]; op_b = sc_r[4]; end
      5'd8: begin op_a = sc_r[1]; op_b = sc_r[2]; end
      5'd9: begin op_a = ad_r; op_b = sc_r[4]; end
      5'd10: begin op_a = sc_r[1]; op_b = sc_r[5]; end
      5'd11: begin op_a = ad_r; op_b = sc_r[5]; end
      5'd12: begin op_a = sc_r[1]; op_b = sc_r[4]; end
      5'd13: begin op_a = sc_r[0]; op_b = sc_r[2]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
    prod = erv_pkg::mulq(op_a, op_b);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (start) st_nxt = ST_PREP;
      ST_PREP: st_nxt = ST_RAD;
      ST_RAD: st_nxt = ST_ITER;
      ST_ITER: if (it_r == 5'(LastIt)) st_nxt = ST_FIN;
      ST_FIN: st_nxt = (ang_sel_r == 2'd2) ? ST_MAT : ST_PREP;
      ST_MAT: if (mstep_r == 5'd14) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ang_sel_r <= '0;
      it_r <= '0;
      mstep_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: begin ang_sel_r <= '0; mstep_r <= '0; end
        ST_RAD: it_r <= '0;
        ST_ITER: it_r <= it_r + 5'd1;
        ST_FIN: ang_sel_r <= ang_sel_r + 2'd1;
        ST_MAT: mstep_r <= mstep_r + 5'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_PREP: begin
        quad_r <= quad_nxt;
        rem_r <= rem_nxt;
      end
      ST_RAD: begin
        cz_r <= 34'(rad_q30);
        cx_r <= 34'(erv_pkg::CORDIC_X0);
        cy_r <= '0;
      end
      ST_ITER: begin
        if (cz_r >= 0) begin
          cx_r <= cx_r - (cy_r >>> it_r);
          cy_r <= cy_r + (cx_r >>> it_r);
          cz_r <= cz_r - erv_pkg::atan_q30(it_r);
        end else begin
          cx_r <= cx_r + (cy_r >>> it_r);
          cy_r <= cy_r - (cx_r >>> it_r);
          cz_r <= cz_r + erv_pkg::atan_q30(it_r);
        end
      end
      ST_FIN: begin
        case (quad_r)
          2'd0: begin sc_r[{ang_sel_r, 1'b1} - 1] <= c_cl; sc_r[{ang_sel_r, 1'b1}] <= s_cl; end
          2'd1: begin sc_r[{ang_sel_r, 1'b1} - 1] <= -s_cl; sc_r[{ang_sel_r, 1'b1}] <= c_cl; end
          2'd2: begin sc_r[{ang_sel_r, 1'b1} - 1] <= -c_cl; sc_r[{ang_sel_r, 1'b1}] <= -s_cl; end
          default: begin sc_r[{ang_sel_r, 1'b1} - 1] <= s_cl; sc_r[{ang_sel_r, 1'b1}] <= -c_cl; end
        endcase
      end
      ST_MAT: begin
        case (mstep_r)
          5'd0: ad_r <= prod;
          5'd1: bd_r <= prod;
          5'd4, 5'd6, 5'd9, 5'd11: t_r <= prod;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Entry writes in the matrix sequence.
  always_comb begin
    wr_en = 1'b0;
    wr_idx = '0;
    wr_data = '0;
    if (st_r == ST_MAT) begin
      wr_en = 1'b1;
      case (mstep_r)
        5'd2: begin wr_idx = 4'd0; wr_data = erv_pkg::clamp_q30(prod); end
        5'd3: begin wr_idx = 4'd1; wr_data = erv_pkg::clamp_q30(-prod); end
        5'd5: begin wr_idx = 4'd3; wr_data = erv_pkg::clamp_q30(t_r + prod); end
        5'd7: begin wr_idx = 4'd4; wr_data = erv_pkg::clamp_q30(prod - t_r); end
        5'd8: begin wr_idx = 4'd5; wr_data = erv_pkg::clamp_q30(-prod); end
        5'd10: begin wr_idx = 4'd6; wr_data = erv_pkg::clamp_q30(prod - t_r); end
        5'd12: begin wr_idx = 4'd7; wr_data = erv_pkg::clamp_q30(t_r + prod); end
        5'd13: begin wr_idx = 4'd8; wr_data = erv_pkg::clamp_q30(prod); end
        5'd14: begin wr_idx = 4'd2; wr_data = erv_pkg::clamp_q30(sc_r[3]); end
        default: wr_en = 1'b0;
      endcase
    end
  end

  assign busy = (st_r != ST_IDLE);

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !wr_en) else $error("matrix write while idle");
  a_mat_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MAT && mstep_r == 5'd14) |=> (st_r == ST_IDLE))
    else $error("matrix sequence overrun");
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_idx <= 4'd8)) else $error("entry index out of range");
`endif
endmodule

>>> rtl/erv_dot_lane.sv
// One output component: three 32x32 products in stage 1, sum, round and
// saturate in stage 2.
module erv_dot_lane (
  input  logic clk,
  input  logic en1,
  input  logic en2,
  input  erv_pkg::coef_t m0,
  input  erv_pkg::coef_t m1,
  input  erv_pkg::coef_t m2,
  input  logic signed [erv_pkg::VecW-1:0] vx,
  input  logic signed [erv_pkg::VecW-1:0] vy,
  input  logic signed [erv_pkg::VecW-1:0] vz,
  output logic signed [erv_pkg::VecW-1:0] res
);
  logic signed [63:0] p0_r, p1_r, p2_r;
  logic signed [65:0] acc;
  logic signed [35:0] sh;
  logic signed [erv_pkg::VecW-1:0] res_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      p0_r <= m0 * vx;
      p1_r <= m1 * vy;
      p2_r <= m2 * vz;
    end
  end

  always_comb begin
    acc = 66'(p0_r) + 66'(p1_r) + 66'(p2_r) + 66'sd536870912;
    sh = acc[65:30];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      if (sh > 36'sd2147483647) res_r <= 32'h7FFFFFFF;
      else if (sh < -36'sd2147483648) res_r <= 32'h80000000;
      else res_r <= sh[31:0];
    end
  end

  assign res = res_r;
endmodule

>>> rtl/euler_rotation_vector_transform.sv
// Euler rotation of Q16.16 vectors by a matrix held in Q1.30.
// Configuration channel: cfg_valid/cfg_ready with cfg_index (0 angle x,
// 1 angle y, 2 angle z, others ignored) and cfg_data, a signed angle in
// 1/64 degree units. A write starts a rebuild of the matrix with a shared
// CORDIC, during which no vector and no further write is taken.
// Input channel: in_valid/in_ready carrying op and the vector; op 0 applies
// the matrix, op 1 its transpose. Output channel: out_valid/out_ready.
// Three lanes, one per output component, each multiply the selected row or
// column in a first stage and sum, round and saturate in a second; a third
// register holds the result. One transaction is taken every cycle while no
// write is pending and no rebuild runs. When the receiver stalls, the
// pipeline holds and stops taking input only once every stage is full.
// Reset loads the identity matrix and zero angles and empties the pipeline.
module euler_rotation_vector_transform #(
  parameter int CORDIC_STEPS = erv_pkg::CordicStepsDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [erv_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [erv_pkg::AngleW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  erv_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output erv_pkg::out_item_t out_data
);
  logic signed [erv_pkg::AngleW-1:0] ax_r, ay_r, az_r;
  erv_pkg::coef_t mat_r [9];
  logic busy, wr_en, start;
  logic [3:0] wr_idx;
  erv_pkg::coef_t wr_data;
  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;
  logic signed [erv_pkg::VecW-1:0] rx, ry, rz;
  erv_pkg::coef_t c [9];

  assign cfg_ready = !busy && !v1_r && !v2_r && !v3_r;
  assign start = cfg_valid && cfg_ready && (cfg_index <= erv_pkg::REG_ANGLE_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ay_r <= '0; az_r <= '0;
      for (int k = 0; k < 9; k++) mat_r[k] <= (k % 4 == 0) ? erv_pkg::ONE_Q30 : '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          erv_pkg::REG_ANGLE_X: ax_r <= cfg_data;
          erv_pkg::REG_ANGLE_Y: ay_r <= cfg_data;
          erv_pkg::REG_ANGLE_Z: az_r <= cfg_data;
          default: ;
        endcase
      end
      if (wr_en) mat_r[wr_idx] <= wr_data;
    end
  end

  erv_matrix_build #(.CORDIC_STEPS(CORDIC_STEPS)) u_build (
    .clk(clk), .rst_n(rst_n), .start(start),
    .ang_x(ax_r), .ang_y(ay_r), .ang_z(az_r),
    .busy(busy), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
  );

  // The transpose swaps the off-diagonal pairs.
  always_comb begin
    for (int k = 0; k < 9; k++) c[k] = mat_r[k];
    if (in_data.op) begin
      c[1] = mat_r[3]; c[3] = mat_r[1];
      c[2] = mat_r[6]; c[6] = mat_r[2];
      c[5] = mat_r[7]; c[7] = mat_r[5];
    end
  end

  assign adv3 = !v3_r || out_ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  // A pending configuration write holds off vectors so that the pipeline
  // drains and the write never shares an edge with a vector transaction.
  assign in_ready = adv1 && !busy && !cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid && in_ready;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  erv_dot_lane u_lx (.clk(clk), .en1(adv1), .en2(adv2), .m0(c[0]), .m1(c[1]),
    .m2(c[2]), .vx(in_data.in_x), .vy(in_data.in_y), .vz(in_data.in_z), .res(rx));
  erv_dot_lane u_ly (.clk(clk), .en1(adv1), .en2(adv2), .m0(c[3]), .m1(c[4]),
    .m2(c[5]), .vx(in_data.in_x), .vy(in_data.in_y), .vz(in_data.in_z), .res(ry));
  erv_dot_lane u_lz (.clk(clk), .en1(adv1), .en2(adv2), .m0(c[6]), .m1(c[7]),
    .m2(c[8]), .vx(in_data.in_x), .vy(in_data.in_y), .vz(in_data.in_z), .res(rz));

  // The merging stage packs the three lanes into the result transaction.
  always_ff @(posedge clk) begin
    if (adv3) begin
      out_data.out_x <= rx;
      out_data.out_y <= ry;
      out_data.out_z <= rz;
    end
  end

  assign out_valid = v3_r;

`ifndef ASSERT_OFF
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready) else $error("vector taken during rebuild");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> (!v1_r && !v2_r && !out_valid)) else $error("write with work in flight");
`endif
endmodule
